### hw/rtl/brmq_pkg.sv
// Shared types and constants for the block range minimum/maximum query engine.
// Used by every module under hw/rtl; depends on nothing else.
`default_nettype none

package brmq_pkg;

   localparam int DEPTH       = 4096;
   localparam int BLOCK_SIZE  = 64;
   localparam int IDX_W       = $clog2(DEPTH);
   localparam int OFF_W       = $clog2(BLOCK_SIZE);
   localparam int BLK_W       = IDX_W - OFF_W;
   localparam int NUM_BLOCKS  = DEPTH / BLOCK_SIZE;
   localparam int COUNT_W     = IDX_W + 1;
   localparam int VAL_W       = 30;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // Request kinds as they arrive on the input channel.
   localparam logic KIND_APPEND = 1'b0;
   localparam logic KIND_QUERY  = 1'b1;

   // Result status codes.
   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

   // Commands passed from the front end to the execution unit.
   localparam logic [1:0] OP_APPEND = 2'd0;
   localparam logic [1:0] OP_QUERY  = 2'd1;
   localparam logic [1:0] OP_REJECT = 2'd2;

   typedef struct packed {
      logic             kind;
      logic [VAL_W-1:0] value;
      logic [11:0]      first_index;
      logic [11:0]      last_index;
   } req_type;

   typedef struct packed {
      logic [VAL_W-1:0] range_min;
      logic [VAL_W-1:0] range_max;
      logic             status;
   } rsp_type;

   // For an append, first_index carries the store index it is written to.
   typedef struct packed {
      logic [1:0]       op;
      logic [VAL_W-1:0] value;
      logic [IDX_W-1:0] first_index;
      logic [IDX_W-1:0] last_index;
   } cmd_type;

   typedef struct packed {
      logic    push;
      cmd_type cmd;
   } cmd_push_type;

endpackage

`default_nettype wire

### hw/rtl/block_range_min_max_query.sv
// Block range minimum/maximum query engine.
// An item is transferred on a rising edge with start high and busy low. Kind
// zero appends its value at the next free index (ignored once 4096 entries are
// held) and gives no result; kind one asks for the minimum and maximum over the
// inclusive index range first_index..last_index.
// A query result appears on rsp_item for one cycle with rsp_strobe high; the
// receiver cannot hold it off. A reversed range, or one reaching past the
// loaded entries, returns status 1 with both values zero.
// A four-entry command queue sits between the front end and the execution unit,
// so busy rises only when that queue is full. A query reads each element of its
// partial end blocks in turn and takes each whole block of 64 from the block
// summaries; the execution unit takes no new command until it has issued the
// result. An item queued behind others waits for them first.
// Synchronous reset empties the store and the queue; no clearing pass is run.
// Depends on brmq_pkg, brmq_front, brmq_queue and brmq_back.
`default_nettype none

module block_range_min_max_query (
   input  wire               clock,
   input  wire               reset,
   input  wire               start,
   output logic              busy,
   input  brmq_pkg::req_type req_item,
   output logic              rsp_strobe,
   output brmq_pkg::rsp_type rsp_item
);

   brmq_pkg::cmd_push_type cmd_push;
   brmq_pkg::cmd_type      head;
   logic                   queue_full;
   logic                   queue_valid;
   logic                   queue_pop;

   assign busy = queue_full;

   brmq_front u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .queue_full (queue_full),
      .req_item   (req_item),
      .cmd_push   (cmd_push)
   );

   brmq_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .cmd_push (cmd_push),
      .full     (queue_full),
      .pop      (queue_pop),
      .valid    (queue_valid),
      .head     (head)
   );

   brmq_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (queue_valid),
      .cmd        (head),
      .cmd_pop    (queue_pop),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule

`default_nettype wire

### hw/rtl/brmq_front.sv
// Front end: accepts requests, tracks the fill count and classifies each item.
// Depends on brmq_pkg.
`default_nettype none

module brmq_front (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    start,
   input  wire                    queue_full,
   input  brmq_pkg::req_type      req_item,
   output brmq_pkg::cmd_push_type cmd_push
);

   logic [brmq_pkg::COUNT_W-1:0] count_ff;
   logic [brmq_pkg::COUNT_W-1:0] count_in;
   logic                         accept;
   logic                         store_full;
   logic                         bad_range;

   assign accept     = start && !queue_full;
   assign store_full = (count_ff == brmq_pkg::COUNT_W'(brmq_pkg::DEPTH));
   assign bad_range  = (req_item.first_index > req_item.last_index) ||
                       ({1'b0, req_item.last_index} >= count_ff);

   always_comb begin
      count_in                  = count_ff;
      cmd_push.push             = 1'b0;
      cmd_push.cmd.op           = brmq_pkg::OP_QUERY;
      cmd_push.cmd.value        = req_item.value;
      cmd_push.cmd.first_index  = req_item.first_index;
      cmd_push.cmd.last_index   = req_item.last_index;
      if (accept) begin
         if (req_item.kind == brmq_pkg::KIND_APPEND) begin
            // An append to a full store is dropped without a trace.
            if (!store_full) begin
               cmd_push.push            = 1'b1;
               cmd_push.cmd.op          = brmq_pkg::OP_APPEND;
               cmd_push.cmd.first_index = count_ff[brmq_pkg::IDX_W-1:0];
               count_in                 = count_ff + brmq_pkg::COUNT_W'(1);
            end
         end else begin
            cmd_push.push   = 1'b1;
            cmd_push.cmd.op = bad_range ? brmq_pkg::OP_REJECT : brmq_pkg::OP_QUERY;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/brmq_queue.sv
// Short command queue between the front end and the execution unit.
// Depends on brmq_pkg.
`default_nettype none

module brmq_queue (
   input  wire                    clock,
   input  wire                    reset,
   input  brmq_pkg::cmd_push_type cmd_push,
   output logic                   full,
   input  wire                    pop,
   output logic                   valid,
   output brmq_pkg::cmd_type      head
);

   brmq_pkg::cmd_type              slot_ff [brmq_pkg::QUEUE_DEPTH];
   logic [brmq_pkg::QPTR_W-1:0]    wr_ptr_ff;
   logic [brmq_pkg::QPTR_W-1:0]    wr_ptr_in;
   logic [brmq_pkg::QPTR_W-1:0]    rd_ptr_ff;
   logic [brmq_pkg::QPTR_W-1:0]    rd_ptr_in;
   logic [brmq_pkg::QPTR_W:0]      fill_ff;
   logic [brmq_pkg::QPTR_W:0]      fill_in;
   logic                           do_push;
   logic                           do_pop;

   assign full    = (fill_ff == (brmq_pkg::QPTR_W + 1)'(brmq_pkg::QUEUE_DEPTH));
   assign valid   = (fill_ff != '0);
   assign head    = slot_ff[rd_ptr_ff];
   assign do_push = cmd_push.push && !full;
   assign do_pop  = pop && valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + brmq_pkg::QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + brmq_pkg::QPTR_W'(1) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + (brmq_pkg::QPTR_W + 1)'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - (brmq_pkg::QPTR_W + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= cmd_push.cmd;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/brmq_back.sv
// Execution unit: holds the value store and the per-block summaries, performs
// appends and walks query ranges. Depends on brmq_pkg.
`default_nettype none

module brmq_back (
   input  wire                clock,
   input  wire                reset,
   input  wire                cmd_valid,
   input  brmq_pkg::cmd_type  cmd,
   output logic               cmd_pop,
   output logic               rsp_strobe,
   output brmq_pkg::rsp_type  rsp_item
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_HEAD  = 3'd1;
   localparam logic [2:0] ST_TAIL  = 3'd2;
   localparam logic [2:0] ST_WHOLE = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   localparam int VW = brmq_pkg::VAL_W;
   localparam int IW = brmq_pkg::IDX_W;
   localparam int OW = brmq_pkg::OFF_W;
   localparam int CW = brmq_pkg::COUNT_W;

   logic [VW-1:0] value_mem [brmq_pkg::DEPTH];
   logic [VW-1:0] bmin_mem  [brmq_pkg::NUM_BLOCKS];
   logic [VW-1:0] bmax_mem  [brmq_pkg::NUM_BLOCKS];

   logic [2:0]        phase_ff, phase_in;
   logic [CW-1:0]     s_ff, s_in;
   logic [IW-1:0]     e_ff, e_in;
   logic [VW-1:0]     lo_ff, lo_in, hi_ff, hi_in;
   logic [VW-1:0]     cur_min_ff, cur_max_ff;
   logic              pend_val_ff, pend_blk_ff;
   logic [VW-1:0]     val_rd_ff, bmin_rd_ff, bmax_rd_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   brmq_pkg::rsp_type rsp_item_ff, rsp_item_in;

   logic                        val_rd_en;
   logic [IW-1:0]               val_rd_addr;
   logic                        blk_rd_en;
   logic                        app_en;
   logic [IW-1:0]               app_idx;
   logic [brmq_pkg::BLK_W-1:0]  app_blk;
   logic [VW-1:0]               app_min, app_max;
   logic                        s_le_e;
   logic [VW-1:0]               cand_lo, cand_hi;

   assign s_le_e  = (s_ff <= {1'b0, e_ff});
   assign app_idx = cmd.first_index;
   assign app_blk = app_idx[IW-1:OW];

   // The first append of a block starts its summary afresh.
   always_comb begin
      if (app_idx[OW-1:0] == '0) begin
         app_min = cmd.value;
         app_max = cmd.value;
      end else begin
         app_min = (cmd.value < cur_min_ff) ? cmd.value : cur_min_ff;
         app_max = (cmd.value > cur_max_ff) ? cmd.value : cur_max_ff;
      end
   end

   // Fold whichever read came back in the previous cycle.
   assign cand_lo = pend_blk_ff ? bmin_rd_ff : val_rd_ff;
   assign cand_hi = pend_blk_ff ? bmax_rd_ff : val_rd_ff;

   always_comb begin
      phase_in     = phase_ff;
      s_in         = s_ff;
      e_in         = e_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      cmd_pop      = 1'b0;
      app_en       = 1'b0;
      val_rd_en    = 1'b0;
      val_rd_addr  = s_ff[IW-1:0];
      blk_rd_en    = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_item_in  = rsp_item_ff;

      if (pend_val_ff || pend_blk_ff) begin
         if (cand_lo < lo_ff) lo_in = cand_lo;
         if (cand_hi > hi_ff) hi_in = cand_hi;
      end

      unique case (phase_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               unique case (cmd.op)
                  brmq_pkg::OP_APPEND: begin
                     app_en = 1'b1;
                  end
                  brmq_pkg::OP_QUERY: begin
                     s_in     = {1'b0, cmd.first_index};
                     e_in     = cmd.last_index;
                     lo_in    = '1;
                     hi_in    = '0;
                     phase_in = ST_HEAD;
                  end
                  brmq_pkg::OP_REJECT: begin
                     rsp_valid_in          = 1'b1;
                     rsp_item_in.range_min = '0;
                     rsp_item_in.range_max = '0;
                     rsp_item_in.status    = brmq_pkg::STATUS_ERR;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_HEAD: begin
            if (s_le_e && (s_ff[OW-1:0] != '0)) begin
               val_rd_en   = 1'b1;
               val_rd_addr = s_ff[IW-1:0];
               s_in        = s_ff + CW'(1);
            end else begin
               phase_in = ST_TAIL;
            end
         end
         ST_TAIL: begin
            if (s_le_e && (e_ff[OW-1:0] != '1)) begin
               val_rd_en   = 1'b1;
               val_rd_addr = e_ff;
               // Reaching index zero means the range is exhausted.
               if (e_ff == '0) begin
                  phase_in = ST_DONE;
               end else begin
                  e_in = e_ff - IW'(1);
               end
            end else begin
               phase_in = ST_WHOLE;
            end
         end
         ST_WHOLE: begin
            if (s_le_e && (e_ff[OW-1:0] == '1)) begin
               blk_rd_en = 1'b1;
               s_in      = s_ff + CW'(brmq_pkg::BLOCK_SIZE);
            end else begin
               phase_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!pend_val_ff && !pend_blk_ff) begin
               rsp_valid_in          = 1'b1;
               rsp_item_in.range_min = lo_ff;
               rsp_item_in.range_max = hi_ff;
               rsp_item_in.status    = brmq_pkg::STATUS_OK;
               phase_in              = ST_IDLE;
            end
         end
         default: begin
            phase_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= ST_IDLE;
         pend_val_ff  <= 1'b0;
         pend_blk_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         pend_val_ff  <= val_rd_en;
         pend_blk_ff  <= blk_rd_en;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s_ff        <= s_in;
      e_ff        <= e_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      rsp_item_ff <= rsp_item_in;
      if (app_en) begin
         cur_min_ff <= app_min;
         cur_max_ff <= app_max;
      end
   end

   always_ff @(posedge clock) begin
      if (app_en) begin
         value_mem[app_idx] <= cmd.value;
      end
      if (val_rd_en) begin
         val_rd_ff <= value_mem[val_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (app_en) begin
         bmin_mem[app_blk] <= app_min;
         bmax_mem[app_blk] <= app_max;
      end
      if (blk_rd_en) begin
         bmin_rd_ff <= bmin_mem[s_ff[IW-1:OW]];
         bmax_rd_ff <= bmax_mem[s_ff[IW-1:OW]];
      end
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_item   = rsp_item_ff;

endmodule

`default_nettype wire
